// ===== hw/rtl/cdf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame deframer package
// Shared types, codes, reset values and the CRC-16 byte update.
// ----------------------------------------------------------------------------
package cdf_pkg;

  localparam int unsigned LEN_W = 7;

  localparam logic [7:0]  HEADER_FIRST_RST  = 8'hAA;
  localparam logic [7:0]  HEADER_SECOND_RST = 8'h55;
  localparam logic [7:0]  TAIL_VALUE_RST    = 8'h55;
  localparam logic [15:0] CRC_SEED_RST      = 16'hFFFF;
  localparam logic [15:0] CRC_POLY          = 16'h1021;

  typedef enum logic [2:0] {
    PH_HEAD0,
    PH_HEAD1,
    PH_CMD,
    PH_LEN,
    PH_PAY,
    PH_CRCL,
    PH_CRCH,
    PH_TAIL
  } ph_e;

  typedef enum logic [2:0] {
    EV_PAYLOAD  = 3'd0,
    EV_EMPTY    = 3'd1,
    EV_LEN_ERR  = 3'd2,
    EV_CRC_ERR  = 3'd3,
    EV_TAIL_ERR = 3'd4
  } ev_e;

  typedef enum logic [1:0] {
    CFG_HEADER_FIRST,
    CFG_HEADER_SECOND,
    CFG_TAIL_VALUE,
    CFG_CRC_SEED
  } cfg_idx_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_PREP,
    BK_DUMP
  } bk_e;

  typedef struct packed {
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic [2:0] event_res;
    logic [7:0] command;
    logic [5:0] payload_length;
    logic [5:0] byte_index;
    logic [7:0] payload_byte;
    logic       last_of_run;
  } res_t;

  typedef struct packed {
    ev_e              ev;
    logic [7:0]       command;
    logic [LEN_W-1:0] length;
  } job_t;

  typedef struct packed {
    logic             we;
    logic [LEN_W-1:0] addr;
    logic [7:0]       data;
  } pay_wr_t;

  function automatic logic [15:0] crc_feed(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/cdf_stream_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stream channel
// Valid/ready channel carrying one payload item per request.
// ----------------------------------------------------------------------------
interface cdf_stream_if #(
  parameter type T = logic [7:0]
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/cdf_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame parser
// Holds the configuration, walks the frame byte by byte, runs the CRC,
// writes payload bytes and posts one job per finished or failed frame.
// ----------------------------------------------------------------------------
module cdf_front import cdf_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD = 57
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  cdf_stream_if.sink  rx_i,
  output job_t        job_o,
  output logic        job_valid_o,
  input  logic        job_ready_i,
  output pay_wr_t     wr_o,
  input  logic        dump_done_i
);

  ph_e              ph_q, ph_d;
  logic [7:0]       cmd_q, cmd_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [LEN_W-1:0] wp_q, wp_d, wp_inc;
  logic [7:0]       crc_lo_q, crc_lo_d;
  logic [15:0]      crc_q, crc_d;
  logic             dump_q, dump_d;
  logic [7:0]       hdr1_q, hdr2_q, tail_q;
  logic [15:0]      seed_q;
  logic [7:0]       b;
  logic             acc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr1_q <= HEADER_FIRST_RST;
      hdr2_q <= HEADER_SECOND_RST;
      tail_q <= TAIL_VALUE_RST;
      seed_q <= CRC_SEED_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_HEADER_FIRST:  hdr1_q <= cfg_data_i[7:0];
        CFG_HEADER_SECOND: hdr2_q <= cfg_data_i[7:0];
        CFG_TAIL_VALUE:    tail_q <= cfg_data_i[7:0];
        CFG_CRC_SEED:      seed_q <= cfg_data_i;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q     <= PH_HEAD0;
      cmd_q    <= '0;
      len_q    <= '0;
      wp_q     <= '0;
      crc_lo_q <= '0;
      crc_q    <= CRC_SEED_RST;
      dump_q   <= 1'b0;
    end else begin
      ph_q     <= ph_d;
      cmd_q    <= cmd_d;
      len_q    <= len_d;
      wp_q     <= wp_d;
      crc_lo_q <= crc_lo_d;
      crc_q    <= crc_d;
      dump_q   <= dump_d;
    end
  end

  always_comb begin
    b           = rx_i.data.rx_byte;
    rx_i.ready  = job_ready_i && !(ph_q == PH_PAY && dump_q);
    acc         = rx_i.valid && rx_i.ready;
    wp_inc      = LEN_W'(wp_q + 1'b1);
    ph_d        = ph_q;
    cmd_d       = cmd_q;
    len_d       = len_q;
    wp_d        = wp_q;
    crc_lo_d    = crc_lo_q;
    crc_d       = crc_q;
    dump_d      = dump_q && !dump_done_i;
    job_valid_o = 1'b0;
    job_o       = '{ev: EV_TAIL_ERR, command: cmd_q, length: len_q};
    wr_o        = '{we: 1'b0, addr: wp_q, data: b};
    if (acc) begin
      unique case (ph_q)
        PH_HEAD0: begin
          if (b == hdr1_q) ph_d = PH_HEAD1;
        end
        PH_HEAD1: begin
          if (b == hdr2_q) begin
            ph_d = PH_CMD;
          end else if (b == hdr1_q) begin
            ph_d = PH_HEAD1;
          end else begin
            ph_d = PH_HEAD0;
          end
        end
        PH_CMD: begin
          cmd_d = b;
          crc_d = crc_feed(seed_q, b);
          ph_d  = PH_LEN;
        end
        PH_LEN: begin
          wp_d = '0;
          if ({1'b0, b} > 9'(MAX_PAYLOAD)) begin
            job_valid_o  = 1'b1;
            job_o.ev     = EV_LEN_ERR;
            job_o.length = '0;
            ph_d         = PH_HEAD0;
          end else begin
            len_d = b[LEN_W-1:0];
            crc_d = crc_feed(crc_q, b);
            ph_d  = (b == 8'd0) ? PH_CRCL : PH_PAY;
          end
        end
        PH_PAY: begin
          wr_o.we = 1'b1;
          wp_d    = wp_inc;
          crc_d   = crc_feed(crc_q, b);
          if (wp_inc >= len_q) ph_d = PH_CRCL;
        end
        PH_CRCL: begin
          crc_lo_d = b;
          ph_d     = PH_CRCH;
        end
        PH_CRCH: begin
          if ({b, crc_lo_q} != crc_q) begin
            job_valid_o = 1'b1;
            job_o.ev    = EV_CRC_ERR;
            ph_d        = PH_HEAD0;
            wp_d        = '0;
          end else begin
            ph_d = PH_TAIL;
          end
        end
        PH_TAIL: begin
          job_valid_o = 1'b1;
          if (b == tail_q) begin
            if (len_q == '0) begin
              job_o.ev = EV_EMPTY;
            end else begin
              job_o.ev = EV_PAYLOAD;
              dump_d   = 1'b1;
            end
          end
          ph_d = PH_HEAD0;
          wp_d = '0;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_no_write_during_dump: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_o.we |-> !dump_q)
    else $error("Payload store written while a dump is pending.");
  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_o |-> job_ready_i)
    else $error("Job posted into a full queue.");
`endif

endmodule

// ===== hw/rtl/cdf_job_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Job queue
// Two-entry queue of frame jobs between the parser and the emitter.
// ----------------------------------------------------------------------------
module cdf_job_fifo import cdf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  job_t push_data_i,
  input  logic push_i,
  output logic push_ready_o,
  output job_t pop_data_o,
  output logic pop_valid_o,
  input  logic pop_i
);

  localparam int unsigned DEPTH = 2;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  job_t             entry_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             push_ok, pop_ok;

  assign push_ready_o = cnt_q != CNT_W'(DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_data_o   = entry_q[rd_ptr_q];
  assign push_ok      = push_i && push_ready_o;
  assign pop_ok       = pop_i && pop_valid_o;

  always_ff @(posedge clk_i) begin
    if (push_ok) entry_q[wr_ptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_ok) wr_ptr_q <= PTR_W'(wr_ptr_q + 1'b1);
      if (pop_ok) rd_ptr_q <= PTR_W'(rd_ptr_q + 1'b1);
      if (push_ok && !pop_ok) begin
        cnt_q <= CNT_W'(cnt_q + 1'b1);
      end else if (pop_ok && !push_ok) begin
        cnt_q <= CNT_W'(cnt_q - 1'b1);
      end
    end
  end

`ifndef SYNTH
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> pop_valid_o)
    else $error("Job popped from an empty queue.");
`endif

endmodule

// ===== hw/rtl/cdf_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result emitter
// Owns the payload store, takes jobs from the queue and drives one result per
// request, reading the store one byte a cycle for a good frame unless stalled.
// ----------------------------------------------------------------------------
module cdf_back import cdf_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD = 57
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  pay_wr_t      wr_i,
  input  job_t         job_i,
  input  logic         job_valid_i,
  output logic         job_pop_o,
  output logic         dump_done_o,
  cdf_stream_if.source res_o
);

  localparam int unsigned AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  logic [7:0]       mem_q [MAX_PAYLOAD];
  logic [7:0]       rd_data_q;
  logic [AW-1:0]    rd_addr;
  bk_e              st_q, st_d;
  logic [LEN_W-1:0] idx_q, idx_d, idx_inc;
  logic [7:0]       cmd_q, cmd_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic             out_valid_q, out_valid_d;
  res_t             out_q, out_d;
  logic             adv;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) mem_q[wr_i.addr[AW-1:0]] <= wr_i.data;
    rd_data_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= BK_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    len_q <= len_d;
    out_q <= out_d;
  end

  assign res_o.valid = out_valid_q;
  assign res_o.data  = out_q;

  always_comb begin
    adv         = !out_valid_q || res_o.ready;
    idx_inc     = LEN_W'(idx_q + 1'b1);
    st_d        = st_q;
    idx_d       = idx_q;
    cmd_d       = cmd_q;
    len_d       = len_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !res_o.ready;
    rd_addr     = idx_q[AW-1:0];
    job_pop_o   = 1'b0;
    dump_done_o = 1'b0;
    unique case (st_q)
      BK_IDLE: begin
        if (job_valid_i && adv) begin
          job_pop_o = 1'b1;
          if (job_i.ev == EV_PAYLOAD) begin
            cmd_d = job_i.command;
            len_d = job_i.length;
            st_d  = BK_PREP;
          end else begin
            out_valid_d = 1'b1;
            out_d = '{event_res: job_i.ev, command: job_i.command,
                      payload_length: job_i.length[5:0], byte_index: 6'd0,
                      payload_byte: 8'd0, last_of_run: 1'b1};
          end
        end
      end
      BK_PREP: begin
        st_d = BK_DUMP;
      end
      BK_DUMP: begin
        if (adv) begin
          rd_addr     = idx_inc[AW-1:0];
          out_valid_d = 1'b1;
          out_d = '{event_res: EV_PAYLOAD, command: cmd_q,
                    payload_length: len_q[5:0], byte_index: idx_q[5:0],
                    payload_byte: rd_data_q, last_of_run: idx_inc == len_q};
          if (idx_inc == len_q) begin
            idx_d       = '0;
            st_d        = BK_IDLE;
            dump_done_o = 1'b1;
          end else begin
            idx_d = idx_inc;
          end
        end
      end
      default: begin
        st_d = BK_IDLE;
      end
    endcase
  end

`ifndef SYNTH
  a_status_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.data.last_of_run) |-> (res_o.data.event_res == EV_PAYLOAD))
    else $error("A status result is not marked as last.");
  a_job_only_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop_o |-> (st_q == BK_IDLE && job_valid_i))
    else $error("Job taken while a dump is in progress.");
`endif

endmodule

// ===== hw/rtl/crc_checked_frame_deframer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC-checked frame deframer
// Takes one received byte per request and delivers payload or status results.
// ----------------------------------------------------------------------------
// Throughput is one byte per cycle. Payload bytes of a new frame wait while the
// previous good frame is still being read out of the payload store, and every
// byte waits while the two-entry job queue is full.
// A status result goes through the job queue and result register; a good frame
// passes the queue and prep state, then yields one result per cycle unless stalled.
// Reset is asynchronous and active low; the payload store needs no clearing.
module crc_checked_frame_deframer import cdf_pkg::*; #(
  parameter int unsigned MAX_FRAME_BYTES = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [15:0]  cfg_data_i,
  cdf_stream_if.sink   rx_i,
  cdf_stream_if.source res_o
);

  localparam int unsigned MAX_PAYLOAD = MAX_FRAME_BYTES - 7;

  job_t    push_job, pop_job;
  logic    push_valid, push_ready, pop_valid, pop;
  pay_wr_t pay_wr;
  logic    dump_done;

  cdf_front #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .rx_i       (rx_i),
    .job_o      (push_job),
    .job_valid_o(push_valid),
    .job_ready_i(push_ready),
    .wr_o       (pay_wr),
    .dump_done_i(dump_done)
  );

  cdf_job_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_data_i (push_job),
    .push_i      (push_valid),
    .push_ready_o(push_ready),
    .pop_data_o  (pop_job),
    .pop_valid_o (pop_valid),
    .pop_i       (pop)
  );

  cdf_back #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (pay_wr),
    .job_i      (pop_job),
    .job_valid_i(pop_valid),
    .job_pop_o  (pop),
    .dump_done_o(dump_done),
    .res_o      (res_o)
  );

endmodule

// ===== sim/crc_checked_frame_deframer_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deframer result checker
// Watches the byte and result channels and the register port of the deframer.
// It tracks the frame parser, header, tail and seed registers on its own,
// queues the results that each accepted byte request should cause, and
// compares every accepted result request with the oldest queued one, field
// by field. It reports the mismatch count and the number of results still due.
// ----------------------------------------------------------------------------
module crc_checked_frame_deframer_chk import cdf_pkg::*; #(
  parameter int unsigned MAX_FRAME_BYTES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        rx_valid_i,
  input  logic        rx_ready_i,
  input  in_t         rx_data_i,
  input  logic        res_valid_i,
  input  logic        res_ready_i,
  input  res_t        res_data_i,
  output int unsigned mismatch_cnt_o,
  output int unsigned pending_o
);

  localparam int unsigned MAX_PAYLOAD = MAX_FRAME_BYTES - 7;
  localparam logic [15:0] POLY        = 16'h1021;

  logic [7:0]  hdr_first;
  logic [7:0]  hdr_second;
  logic [7:0]  tail_byte;
  logic [15:0] seed;
  ph_e         phase;
  logic [7:0]  cmd_q;
  logic [5:0]  len_q;
  logic [5:0]  wr_pos;
  logic [7:0]  crc_lo;
  logic [15:0] crc_run;
  logic [7:0]  pay_mem [MAX_PAYLOAD];
  res_t        results_due [$];

  function automatic logic [15:0] crc16_next(logic [15:0] c, logic [7:0] b);
    logic [15:0] r;
    r = c ^ {b, 8'h00};
    repeat (8) begin
      if (r[15]) begin
        r = {r[14:0], 1'b0} ^ POLY;
      end else begin
        r = {r[14:0], 1'b0};
      end
    end
    return r;
  endfunction

  function automatic res_t make_res(ev_e ev, logic [5:0] len, logic [5:0] idx,
                                    logic [7:0] data, logic last);
    res_t r;
    r.event_res      = ev;
    r.command        = cmd_q;
    r.payload_length = len;
    r.byte_index     = idx;
    r.payload_byte   = data;
    r.last_of_run    = last;
    return r;
  endfunction

  function automatic string fmt_res(res_t r);
    return $sformatf("ev=%0d cmd=%02h len=%0d idx=%0d data=%02h last=%0b",
                     r.event_res, r.command, r.payload_length, r.byte_index,
                     r.payload_byte, r.last_of_run);
  endfunction

  task automatic take_byte(logic [7:0] b);
    case (phase)
      PH_HEAD0: begin
        if (b == hdr_first) phase = PH_HEAD1;
      end
      PH_HEAD1: begin
        if (b == hdr_second) begin
          phase = PH_CMD;
        end else if (b != hdr_first) begin
          phase = PH_HEAD0;
        end
      end
      PH_CMD: begin
        cmd_q   = b;
        crc_run = crc16_next(seed, b);
        phase   = PH_LEN;
      end
      PH_LEN: begin
        wr_pos = '0;
        if (b > MAX_PAYLOAD) begin
          results_due.push_back(make_res(EV_LEN_ERR, 6'd0, 6'd0, 8'h00, 1'b1));
          phase = PH_HEAD0;
        end else begin
          len_q   = b[5:0];
          crc_run = crc16_next(crc_run, b);
          phase   = (b == 8'd0) ? PH_CRCL : PH_PAY;
        end
      end
      PH_PAY: begin
        pay_mem[wr_pos] = b;
        wr_pos  = wr_pos + 6'd1;
        crc_run = crc16_next(crc_run, b);
        if (wr_pos >= len_q) phase = PH_CRCL;
      end
      PH_CRCL: begin
        crc_lo = b;
        phase  = PH_CRCH;
      end
      PH_CRCH: begin
        if ({b, crc_lo} != crc_run) begin
          results_due.push_back(make_res(EV_CRC_ERR, len_q, 6'd0, 8'h00, 1'b1));
          phase  = PH_HEAD0;
          wr_pos = '0;
        end else begin
          phase = PH_TAIL;
        end
      end
      default: begin
        if (b != tail_byte) begin
          results_due.push_back(make_res(EV_TAIL_ERR, len_q, 6'd0, 8'h00, 1'b1));
        end else if (len_q == 6'd0) begin
          results_due.push_back(make_res(EV_EMPTY, 6'd0, 6'd0, 8'h00, 1'b1));
        end else begin
          for (int i = 0; i < int'(len_q); i++) begin
            results_due.push_back(make_res(EV_PAYLOAD, len_q, 6'(i), pay_mem[i],
                                           (i + 1 == int'(len_q))));
          end
        end
        phase  = PH_HEAD0;
        wr_pos = '0;
      end
    endcase
  endtask

  task automatic check_result(res_t got);
    res_t want;
    if (results_due.size() == 0) begin
      mismatch_cnt_o++;
      if (mismatch_cnt_o <= 10) $display("unexpected result: %s", fmt_res(got));
    end else begin
      want = results_due.pop_front();
      if (got.event_res !== want.event_res || got.command !== want.command ||
          got.payload_length !== want.payload_length ||
          got.byte_index !== want.byte_index ||
          got.payload_byte !== want.payload_byte ||
          got.last_of_run !== want.last_of_run) begin
        mismatch_cnt_o++;
        if (mismatch_cnt_o <= 10) begin
          $display("result mismatch: expected %s, got %s", fmt_res(want), fmt_res(got));
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_first      = HEADER_FIRST_RST;
      hdr_second     = HEADER_SECOND_RST;
      tail_byte      = TAIL_VALUE_RST;
      seed           = CRC_SEED_RST;
      phase          = PH_HEAD0;
      cmd_q          = '0;
      len_q          = '0;
      wr_pos         = '0;
      crc_lo         = '0;
      crc_run        = CRC_SEED_RST;
      mismatch_cnt_o = 0;
      results_due.delete();
    end else begin
      if (res_valid_i && res_ready_i) check_result(res_data_i);
      if (rx_valid_i && rx_ready_i) take_byte(rx_data_i.rx_byte);
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_HEADER_FIRST:  hdr_first  = cfg_data_i[7:0];
          CFG_HEADER_SECOND: hdr_second = cfg_data_i[7:0];
          CFG_TAIL_VALUE:    tail_byte  = cfg_data_i[7:0];
          default:           seed       = cfg_data_i;
        endcase
      end
    end
    pending_o = results_due.size();
  end

endmodule

// ===== sim/crc_checked_frame_deframer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deframer testbench
// Sends directed and random frames, good and broken, under several header,
// tail and seed settings, with random gaps on the byte side and random stalls
// on the result side. The checker beside the block predicts and compares the
// results; this module makes the stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module crc_checked_frame_deframer_tb;
  import cdf_pkg::*;

  typedef enum int {
    FR_GOOD,
    FR_BAD_CRC,
    FR_BAD_TAIL,
    FR_BAD_LEN,
    FR_CUT
  } frame_kind_e;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [15:0] cfg_data;
  logic        rx_fire;
  bit          gaps_on;
  bit          stalls_on;
  logic [7:0]  hdr_first;
  logic [7:0]  hdr_second;
  logic [7:0]  tail_byte;
  logic [15:0] seed;
  int unsigned bytes_sent;
  int unsigned mismatch_cnt;
  int unsigned pending;

  cdf_stream_if #(.T(in_t))  rx_if ();
  cdf_stream_if #(.T(res_t)) res_if ();

  crc_checked_frame_deframer dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .rx_i       (rx_if),
    .res_o      (res_if)
  );

  crc_checked_frame_deframer_chk u_chk (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .rx_valid_i     (rx_if.valid),
    .rx_ready_i     (rx_if.ready),
    .rx_data_i      (rx_if.data),
    .res_valid_i    (res_if.valid),
    .res_ready_i    (res_if.ready),
    .res_data_i     (res_if.data),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_o      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  always_ff @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      rx_fire <= 1'b0;
    end else begin
      rx_fire <= rx_if.valid && rx_if.ready;
    end
  end

  initial begin
    int stall_left;
    res_if.ready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        res_if.ready = 1'b0;
      end else if (stalls_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 11) - 1;
        res_if.ready = 1'b0;
      end else begin
        res_if.ready = 1'b1;
      end
    end
  end

  function automatic logic [15:0] crc16_next(logic [15:0] c, logic [7:0] b);
    logic [15:0] r;
    r = c ^ {b, 8'h00};
    repeat (8) begin
      if (r[15]) begin
        r = {r[14:0], 1'b0} ^ 16'h1021;
      end else begin
        r = {r[14:0], 1'b0};
      end
    end
    return r;
  endfunction

  // Called at a falling edge; returns at the falling edge after the request
  // was taken, with valid still high.
  task automatic push_byte(input logic [7:0] b);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      rx_if.valid = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    rx_if.valid = 1'b1;
    rx_if.data  = b;
    do @(negedge clk); while (!rx_fire);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [7:0] cmd, input logic [7:0] len_b,
                            input frame_kind_e kind, input int fill,
                            input logic [7:0] bad_tail);
    logic [7:0]  bytes_q [$];
    logic [15:0] crc;
    logic [7:0]  b;
    bytes_q.push_back(hdr_first);
    bytes_q.push_back(hdr_second);
    bytes_q.push_back(cmd);
    crc = crc16_next(seed, cmd);
    if (kind != FR_CUT) begin
      bytes_q.push_back(len_b);
      if (kind != FR_BAD_LEN) begin
        crc = crc16_next(crc, len_b);
        for (int i = 0; i < int'(len_b); i++) begin
          b = (fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill);
          bytes_q.push_back(b);
          crc = crc16_next(crc, b);
        end
        if (kind == FR_BAD_CRC) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
        bytes_q.push_back(crc[7:0]);
        bytes_q.push_back(crc[15:8]);
        if (kind == FR_GOOD) begin
          bytes_q.push_back(tail_byte);
        end else if (kind == FR_BAD_TAIL) begin
          bytes_q.push_back((bad_tail != tail_byte) ? bad_tail : ~tail_byte);
        end
      end
    end
    foreach (bytes_q[i]) push_byte(bytes_q[i]);
  endtask

  task automatic random_frame();
    frame_kind_e kind;
    int          r;
    logic [7:0]  len_b;
    if ($urandom_range(0, 9) == 0) push_byte(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 9) == 0) push_byte(hdr_first);
    r = $urandom_range(0, 99);
    if (r < 68) begin
      kind = FR_GOOD;
    end else if (r < 80) begin
      kind = FR_BAD_CRC;
    end else if (r < 90) begin
      kind = FR_BAD_TAIL;
    end else if (r < 96) begin
      kind = FR_BAD_LEN;
    end else begin
      kind = FR_CUT;
    end
    r = $urandom_range(0, 19);
    if (kind == FR_BAD_LEN) begin
      len_b = 8'($urandom_range(58, 255));
    end else if (r == 0) begin
      len_b = 8'd57;
    end else if (r < 4) begin
      len_b = 8'($urandom_range(9, 56));
    end else begin
      len_b = 8'($urandom_range(0, 8));
    end
    send_frame(8'($urandom_range(0, 255)), len_b, kind, -1, 8'($urandom_range(0, 255)));
  endtask

  task automatic drain();
    rx_if.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (64) @(negedge clk);
  endtask

  task automatic set_regs(input logic [7:0] hf, input logic [7:0] hs,
                          input logic [7:0] tl, input logic [15:0] sd);
    cfg_we   = 1'b1;
    cfg_idx  = CFG_HEADER_FIRST;
    cfg_data = {8'h00, hf};
    @(negedge clk);
    cfg_idx  = CFG_HEADER_SECOND;
    cfg_data = {8'h00, hs};
    @(negedge clk);
    cfg_idx  = CFG_TAIL_VALUE;
    cfg_data = {8'h00, tl};
    @(negedge clk);
    cfg_idx  = CFG_CRC_SEED;
    cfg_data = sd;
    @(negedge clk);
    cfg_we     = 1'b0;
    hdr_first  = hf;
    hdr_second = hs;
    tail_byte  = tl;
    seed       = sd;
  endtask

  initial begin
    int unsigned start;
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_idx     = CFG_HEADER_FIRST;
    cfg_data    = '0;
    rx_if.valid = 1'b0;
    rx_if.data  = '0;
    gaps_on     = 1'b1;
    stalls_on   = 1'b1;
    bytes_sent  = 0;
    hdr_first   = HEADER_FIRST_RST;
    hdr_second  = HEADER_SECOND_RST;
    tail_byte   = TAIL_VALUE_RST;
    seed        = CRC_SEED_RST;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Noise, then a repeated first header byte ahead of an empty frame.
    push_byte(8'h00);
    push_byte(hdr_first);
    send_frame(8'hFF, 8'd0, FR_GOOD, 0, 8'h00);
    send_frame(8'h3C, 8'd58, FR_BAD_LEN, 0, 8'h00);
    send_frame(8'h5A, 8'd1, FR_BAD_CRC, 8'hFF, 8'h00);
    // A header byte where the tail belongs is only a bad tail.
    send_frame(8'h00, 8'd1, FR_BAD_TAIL, 8'h00, hdr_first);

    for (int p = 0; p < 4; p++) begin
      drain();
      case (p)
        0: set_regs(8'h00, 8'h00, 8'h00, 16'h0000);
        1: set_regs(8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
        2: set_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
        default: begin
          set_regs(HEADER_FIRST_RST, HEADER_SECOND_RST, TAIL_VALUE_RST, CRC_SEED_RST);
          gaps_on   = 1'b0;
          stalls_on = 1'b0;
        end
      endcase
      start = bytes_sent;
      if (p == 1) send_frame(8'($urandom_range(0, 255)), 8'd57, FR_GOOD, -1, 8'h00);
      while (bytes_sent - start < 4) random_frame();
    end
    drain();

    if (mismatch_cnt == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/cdf_pkg.sv
hw/rtl/cdf_stream_if.sv
hw/rtl/cdf_front.sv
hw/rtl/cdf_job_fifo.sv
hw/rtl/cdf_back.sv
hw/rtl/crc_checked_frame_deframer.sv
sim/crc_checked_frame_deframer_chk.sv
sim/crc_checked_frame_deframer_tb.sv
